### src/dsd_pkg.sv
`timescale 1ns / 1ps

package dsd_pkg;

  // Display geometry and field widths
  localparam int DIGITS = 8;
  localparam int BIN_W  = 27;
  localparam int SEG_W  = 7;
  localparam int BCD_W  = 4;
  localparam int DSEL_W = 3;
  localparam int SCAN_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CNT_W  = $clog2(BIN_W);

  // Operation codes of an input word
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_DONE
  } state_t;

  // Control handed from the sequencer to the digit cells
  typedef struct packed {
    logic clear;
    logic shift;
    logic serial;
    logic done;
    logic busy;
  } cell_ctl_t;

  // Decimal digit to segment pattern, bit0 = a through bit6 = g
  function automatic logic [SEG_W-1:0] seg_code(input logic [BCD_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

### src/dsd_in_if.sv
`timescale 1ns / 1ps

interface dsd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [dsd_pkg::BIN_W-1:0] number;

  modport source (output valid, output op, output number, input ready);
  modport sink   (input valid, input op, input number, output ready);
endinterface

### src/dsd_out_if.sv
`timescale 1ns / 1ps

interface dsd_out_if;
  logic                       valid;
  logic                       ready;
  logic [dsd_pkg::DSEL_W-1:0] digit_select;
  logic [dsd_pkg::SEG_W-1:0]  segments;
  logic                       overflow;

  modport source (output valid, output digit_select, output segments, output overflow,
                  input ready);
  modport sink   (input valid, input digit_select, input segments, input overflow,
                  output ready);
endinterface

### src/dsd_cell.sv
`timescale 1ns / 1ps

module dsd_cell (
  input  logic                        clk,
  input  dsd_pkg::cell_ctl_t          ctl,
  input  logic                        shift_in,
  input  logic                        lead_in,
  input  logic                        force_show,
  output logic                        carry_out,
  output logic                        lead_out,
  output logic [dsd_pkg::SEG_W-1:0]   pattern
);

  logic [dsd_pkg::BCD_W-1:0] digit_r;
  logic [dsd_pkg::BCD_W-1:0] adj;
  logic                      zero;

  // Add three to digits of five and up before the shift
  assign adj       = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  assign carry_out = adj[dsd_pkg::BCD_W-1];

  // Clear on load, shift one bit in per conversion step
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit_r <= '0;
    end else if (ctl.shift) begin
      digit_r <= {adj[dsd_pkg::BCD_W-2:0], shift_in};
    end
  end

  // Blank while every digit to the left, and this one, is zero, unless forced to show
  assign zero     = (digit_r == '0);
  assign lead_out = lead_in & zero;
  assign pattern  = (lead_in && zero && !force_show) ? '0 : dsd_pkg::seg_code(digit_r);

endmodule

### src/dsd_ctrl.sv
`timescale 1ns / 1ps

module dsd_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dsd_pkg::BIN_W-1:0] number,
  output dsd_pkg::cell_ctl_t        ctl
);

  dsd_pkg::state_t             state_r;
  dsd_pkg::state_t             state_nxt;
  logic [dsd_pkg::CNT_W-1:0]   cnt_r;
  logic [dsd_pkg::BIN_W-1:0]   bin_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dsd_pkg::ST_IDLE: if (start) state_nxt = dsd_pkg::ST_CONV;
      dsd_pkg::ST_CONV: if (cnt_r == '0) state_nxt = dsd_pkg::ST_DONE;
      dsd_pkg::ST_DONE: state_nxt = dsd_pkg::ST_IDLE;
      default:          state_nxt = dsd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dsd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the binary word and step count; shift MSB first
  always_ff @(posedge clk) begin
    if (start) begin
      bin_r <= number;
      cnt_r <= dsd_pkg::CNT_W'(dsd_pkg::BIN_W - 1);
    end else if (state_r == dsd_pkg::ST_CONV) begin
      bin_r <= {bin_r[dsd_pkg::BIN_W-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Outputs to the cell row
  always_comb begin
    ctl.clear  = start;
    ctl.shift  = (state_r == dsd_pkg::ST_CONV);
    ctl.serial = bin_r[dsd_pkg::BIN_W-1];
    ctl.done   = (state_r == dsd_pkg::ST_DONE);
    ctl.busy   = (state_r != dsd_pkg::ST_IDLE);
  end

endmodule

### src/eight_digit_seven_segment_driver.sv
`timescale 1ns / 1ps

// Eight-digit multiplexed seven-segment display driver.
// Input channel (in_ch): op selects a load of number (binary) or a refresh
// tick. Result channel (out_ch): one word per input word, giving the digit
// position at the scan pointer, its segment pattern and the overflow flag.
// A tick word returns its result in the cycle after acceptance and then moves
// the scan pointer on, wrapping after the rightmost digit.
// A load word runs a shift-and-add-three conversion through a row of eight
// BCD digit cells, one input bit per cycle for all 27 bits, MSB first; then a
// done state captures the result in the output register, and no new word is
// taken until that state is over. Ticks can follow each other as results are read.
// Leading zeros are blanked; numbers of nine digits set overflow and show
// their low eight digits.
// Reset clears scan pointer, overflow and loaded mark; shown patterns go blank.
// The result sits in an output register; while the receiver stalls it is
// held, and a new word is taken only once that register is free or is
// being read in the same cycle.
module eight_digit_seven_segment_driver (
  input  logic        clk,
  input  logic        rst_n,
  dsd_in_if.sink      in_ch,
  dsd_out_if.source   out_ch
);

  dsd_pkg::cell_ctl_t              ctl;
  logic                            in_acc;
  logic                            start;
  logic                            tick;
  logic [dsd_pkg::DIGITS-1:0]      carry;
  logic [dsd_pkg::DIGITS-1:0]      lead;
  logic [dsd_pkg::SEG_W-1:0]       pat [dsd_pkg::DIGITS];
  logic [dsd_pkg::SEG_W-1:0]       shown_pat;
  logic [dsd_pkg::SCAN_W-1:0]      scan_r;
  logic [dsd_pkg::SCAN_W-1:0]      scan_nxt;
  logic                            loaded_r;
  logic                            ovf_r;
  logic                            out_valid_r;
  logic [dsd_pkg::DSEL_W-1:0]      dsel_r;
  logic [dsd_pkg::SEG_W-1:0]       seg_r;
  logic                            oflag_r;

  // Input handshake
  assign in_ch.ready = !ctl.busy && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign start       = in_acc && (in_ch.op == dsd_pkg::OP_LOAD);
  assign tick        = in_acc && (in_ch.op == dsd_pkg::OP_TICK);

  dsd_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .number (in_ch.number),
    .ctl    (ctl)
  );

  // Row of digit cells, least significant digit at the right end
  for (genvar k = 0; k < dsd_pkg::DIGITS; k++) begin : g_cell
    logic shift_in;
    logic lead_in;
    if (k == dsd_pkg::DIGITS - 1) begin : g_low
      assign shift_in = ctl.serial;
    end else begin : g_mid
      assign shift_in = carry[k+1];
    end
    if (k == 0) begin : g_left
      assign lead_in = 1'b1;
    end else begin : g_rest
      assign lead_in = lead[k-1];
    end
    dsd_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .shift_in   (shift_in),
      .lead_in    (lead_in),
      .force_show (k == dsd_pkg::DIGITS - 1),
      .carry_out  (carry[k]),
      .lead_out   (lead[k]),
      .pattern    (pat[k])
    );
  end

  // Pattern at the scan pointer, blank until the first load
  assign shown_pat = loaded_r ? pat[scan_r] : '0;
  assign scan_nxt  = (scan_r == dsd_pkg::SCAN_W'(dsd_pkg::DIGITS - 1)) ? '0 : scan_r + 1'b1;

  // Scan pointer, loaded mark and sticky overflow from the leftmost cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r   <= '0;
      loaded_r <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      if (tick) begin
        scan_r <= scan_nxt;
      end
      if (start) begin
        loaded_r <= 1'b1;
        ovf_r    <= 1'b0;
      end else if (ctl.shift) begin
        ovf_r <= ovf_r | carry[0];
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick || ctl.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick || ctl.done) begin
      dsel_r  <= dsd_pkg::DSEL_W'(scan_r);
      seg_r   <= shown_pat;
      oflag_r <= ovf_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.digit_select = dsel_r;
  assign out_ch.segments     = seg_r;
  assign out_ch.overflow     = oflag_r;

endmodule
